// ===== sv/fsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// fsfp_pkg
// types and codes shared by the flow sensor frame parser
// ----------------------------------------------------------------------------
package fsfp_pkg;

  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 8;
  localparam int unsigned StoreDepth = 10;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_HEADER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FOOTER = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_VALID  = 2'd2;

  // parser states, one-hot
  typedef enum logic [4:0] {
    ST_HEADER  = 5'b00001,
    ST_LENGTH  = 5'b00010,
    ST_PAYLOAD = 5'b00100,
    ST_CHECK   = 5'b01000,
    ST_FOOTER  = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_LEN_ERR   = 2'd1,
    STAT_CSUM_ERR  = 2'd2,
    STAT_FOOT_ERR  = 2'd3
  } status_e;

  typedef struct packed {
    status_e            status;
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
    logic        [15:0] integ_span;
    logic        [15:0] distance;
    logic               data_valid;
    logic        [7:0]  confidence;
    logic        [31:0] good_frames;
    logic        [31:0] bad_frames;
  } result_t;

endpackage

// ===== sv/flow_sensor_frame_parser.sv =====
// ----------------------------------------------------------------------------
// flow_sensor_frame_parser
// frames optical flow sensor packets from a serial byte stream
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | in_valid_i / in_stall_o    | rx_byte_i
//  out     | output    | out_valid_o / out_stall_i  | status_o .. bad_frames_o
//  cfg     | input     | cfg_we_i                   | cfg_index_i, cfg_data_i
//
//  one byte beat is taken per cycle while in_stall_o is low; its parser step is
//  done in the cycle it is accepted and any result lands on that edge in the
//  result register, or in the skid register while the result register is stalled
//  a two-entry output (result register plus skid register) keeps input open
//  while one result waits; in_stall_o is high only while the skid is full
//  reset clears parser state, counters and both output entries; the payload
//  store is not reset
//
module flow_sensor_frame_parser #(
  parameter int unsigned PAYLOAD_LEN = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // byte input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [fsfp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fsfp_pkg::CfgDataW-1:0] cfg_data_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic signed [15:0]            flow_x_o,
  output logic signed [15:0]            flow_y_o,
  output logic [15:0]                   integ_span_o,
  output logic [15:0]                   distance_o,
  output logic                          data_valid_o,
  output logic [7:0]                    confidence_o,
  output logic [31:0]                   good_frames_o,
  output logic [31:0]                   bad_frames_o
);
  import fsfp_pkg::*;

  localparam logic [3:0] LenByte = 4'(PAYLOAD_LEN);

  // configuration registers
  logic [7:0] header_q, footer_q, valid_code_q;

  // parser state
  state_e      state_q, state_d;
  logic [3:0]  pos_q, pos_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  store_q [StoreDepth];
  logic [31:0] good_q, good_d, bad_q, bad_d;

  // output stage
  result_t out_q, skid_q, res;
  logic    out_valid_q, skid_valid_q;

  logic       in_acc, res_fire, main_free;
  logic [3:0] pos_inc;
  logic       store_we;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i & ~skid_valid_q;
  assign pos_inc    = pos_q + 4'd1;
  assign store_we   = in_acc && (state_q == ST_PAYLOAD) && (pos_q < 4'(StoreDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q     <= 8'd254;
      footer_q     <= 8'd85;
      valid_code_q <= 8'd245;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HEADER: header_q     <= cfg_data_i;
        CFG_FOOTER: footer_q     <= cfg_data_i;
        CFG_VALID:  valid_code_q <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // parser step for the accepted byte
  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    xor_d    = xor_q;
    good_d   = good_q;
    bad_d    = bad_q;
    res_fire = 1'b0;
    res      = '0;
    res.status = STAT_OK;
    if (in_acc) begin
      unique case (state_q)
        ST_LENGTH: begin
          if (rx_byte_i == {4'd0, LenByte}) begin
            state_d = ST_PAYLOAD;
            pos_d   = '0;
            xor_d   = '0;
          end else begin
            state_d    = ST_HEADER;
            bad_d      = bad_q + 32'd1;
            res_fire   = 1'b1;
            res.status = STAT_LEN_ERR;
          end
        end
        ST_PAYLOAD: begin
          xor_d = xor_q ^ rx_byte_i;
          pos_d = pos_inc;
          if (pos_inc >= LenByte || pos_inc == 4'd0) state_d = ST_CHECK;
        end
        ST_CHECK: begin
          if (rx_byte_i == xor_q) begin
            state_d = ST_FOOTER;
          end else begin
            state_d    = ST_HEADER;
            bad_d      = bad_q + 32'd1;
            res_fire   = 1'b1;
            res.status = STAT_CSUM_ERR;
          end
        end
        ST_FOOTER: begin
          state_d  = ST_HEADER;
          res_fire = 1'b1;
          if (rx_byte_i == footer_q) begin
            good_d         = good_q + 32'd1;
            res.status     = STAT_OK;
            res.flow_x     = {store_q[1], store_q[0]};
            res.flow_y     = {store_q[3], store_q[2]};
            res.integ_span = {store_q[5], store_q[4]};
            res.distance   = {store_q[7], store_q[6]};
            res.data_valid = (store_q[8] == valid_code_q);
            res.confidence = store_q[9];
          end else begin
            bad_d      = bad_q + 32'd1;
            res.status = STAT_FOOT_ERR;
          end
        end
        default: begin
          // header search, also covers any stray code
          state_d = (rx_byte_i == header_q) ? ST_LENGTH : ST_HEADER;
        end
      endcase
    end
    res.good_frames = good_d;
    res.bad_frames  = bad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HEADER;
      pos_q   <= '0;
      xor_q   <= '0;
      good_q  <= '0;
      bad_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      xor_q   <= xor_d;
      good_q  <= good_d;
      bad_q   <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) store_q[pos_q] <= rx_byte_i;
  end

  // result register with skid entry behind it
  assign main_free = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (main_free) begin
      out_valid_q  <= skid_valid_q | res_fire;
      skid_valid_q <= 1'b0;
    end else if (res_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_free) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (res_fire) out_q <= res;
    end else if (res_fire) begin
      skid_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign flow_x_o      = out_q.flow_x;
  assign flow_y_o      = out_q.flow_y;
  assign integ_span_o  = out_q.integ_span;
  assign distance_o    = out_q.distance;
  assign data_valid_o  = out_q.data_valid;
  assign confidence_o  = out_q.confidence;
  assign good_frames_o = out_q.good_frames;
  assign bad_frames_o  = out_q.bad_frames;

  // skid only holds a result while the result register is occupied
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty result register");

  // a good frame bumps the good counter by exactly one
  a_good_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_fire && res.status == STAT_OK) |=> good_q == $past(good_q) + 32'd1)
    else $error("good frame counter did not advance");

  // every emitted result sends the parser back to header search
  a_result_resync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire |=> state_q == ST_HEADER)
    else $error("parser not in header search after a result");

  // a byte that produces no result leaves both counters alone
  a_counters_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_fire |=> (good_q == $past(good_q)) && (bad_q == $past(bad_q)))
    else $error("counter changed without a result");

endmodule
